// ===== sv/lsk_pkg.sv =====
// Shared constants and types for the keyed-removal LIFO stack.
`timescale 1ns / 1ps
`default_nettype none

package lsk_pkg;

    localparam int DEPTH_DEFAULT    = 8;
    localparam int KEY_BITS_DEFAULT = 16;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_MISSING = 2'd3;

    // Per-cell controls driven by the stack controller.
    typedef struct packed {
        logic push;     // a push transfer that fits
        logic remove;   // a remove transfer
        logic valid;    // cell holds a stored key
        logic is_load;  // cell is the first free place
        logic is_top;   // cell holds the top key
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/lsk_cell.sv =====
// One stack cell: holds a key, compares it and shifts down on a removal.
`timescale 1ns / 1ps
`default_nettype none

module lsk_cell #(
    parameter int KEY_BITS = lsk_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire lsk_pkg::cell_ctrl_t ctrl,
    input  wire logic [KEY_BITS-1:0] key,
    input  wire logic               any_hit,
    input  wire logic [KEY_BITS-1:0] up_data,
    input  wire logic [KEY_BITS-1:0] top_in,
    input  wire logic               hit_in,
    output logic [KEY_BITS-1:0]     data,
    output logic [KEY_BITS-1:0]     top_out,
    output logic                    hit_out
);

    logic [KEY_BITS-1:0] data_reg;
    logic [KEY_BITS-1:0] data_next;
    logic                match;
    logic                shift;

    assign match   = ctrl.valid && (data_reg == key);
    assign hit_out = hit_in || match;
    // The topmost match is at or below this cell when nothing above matched.
    assign shift   = ctrl.remove && any_hit && !hit_in;
    assign top_out = ctrl.is_top ? data_reg : top_in;
    assign data    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push && ctrl.is_load)
        begin
            data_next = key;
        end
        else if (shift)
        begin
            data_next = up_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== sv/lifo_stack_with_keyed_removal.sv =====
// Top level: LIFO stack of keys with push, pop and remove of the topmost matching key.
//
//   Channel   Ports                         Handshake
//   command   start, busy, kind, key        transfer when start && !busy
//   result    done, status, value,          done high for one cycle, no stall
//             occupancy
//
// Every command settles combinationally: the compare in each cell and the ripple of
// the match flag down the row of cells settle within the cycle of the transfer.
// The result appears with done in the cycle after the command transfer.
// busy stays low, so a command may be given in every cycle.
// Reset empties the stack; stored keys are not cleared.
// The result side cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_keyed_removal #(
    parameter int DEPTH    = lsk_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = lsk_pkg::KEY_BITS_DEFAULT,
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          kind,
    input  wire logic [KEY_BITS-1:0] key,
    output logic                     done,
    output logic [1:0]               status,
    output logic [KEY_BITS-1:0]      value,
    output logic [CNT_W-1:0]         occupancy
);

    logic                accept;
    logic                full;
    logic                empty;
    logic                any_hit;
    logic                push_ok;
    logic                remove_cmd;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [KEY_BITS-1:0] value_reg;
    logic [KEY_BITS-1:0] value_next;

    logic [KEY_BITS-1:0] data_w [DEPTH];
    logic [KEY_BITS-1:0] top_w  [DEPTH+1];
    logic                hit_w  [DEPTH+1];

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign push_ok    = accept && (kind == lsk_pkg::KIND_PUSH) && !full;
    assign remove_cmd = accept && (kind == lsk_pkg::KIND_REMOVE);
    assign any_hit    = hit_w[0];

    assign hit_w[DEPTH] = 1'b0;
    assign top_w[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        lsk_pkg::cell_ctrl_t ctrl;
        logic [KEY_BITS-1:0] up_data;

        assign ctrl.push    = push_ok;
        assign ctrl.remove  = remove_cmd;
        assign ctrl.valid   = (count_reg > CNT_W'(i));
        assign ctrl.is_load = (count_reg == CNT_W'(i));
        assign ctrl.is_top  = (count_reg == CNT_W'(i + 1));

        if (i == DEPTH - 1)
        begin : g_top
            assign up_data = data_w[i];
        end
        else
        begin : g_mid
            assign up_data = data_w[i+1];
        end

        lsk_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .key     (key),
            .any_hit (any_hit),
            .up_data (up_data),
            .top_in  (top_w[i+1]),
            .hit_in  (hit_w[i+1]),
            .data    (data_w[i]),
            .top_out (top_w[i]),
            .hit_out (hit_w[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = lsk_pkg::STATUS_DONE;
        value_next  = '0;
        case (kind)
            lsk_pkg::KIND_PUSH:
            begin
                if (full)
                begin
                    status_next = lsk_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            lsk_pkg::KIND_POP:
            begin
                if (empty)
                begin
                    status_next = lsk_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    value_next = top_w[0];
                end
            end
            lsk_pkg::KIND_REMOVE:
            begin
                if (any_hit)
                begin
                    count_next = count_reg - CNT_W'(1);
                    value_next = key;
                end
                else
                begin
                    status_next = lsk_pkg::STATUS_MISSING;
                end
            end
            default:
            begin
                status_next = lsk_pkg::STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign occupancy = count_reg;

endmodule

`default_nettype wire
